/* rtl/core/segregated_best_fit_allocator_top_defines.svh */
// Assertion macros shared by the allocator RTL.
`ifndef SEGREGATED_BEST_FIT_ALLOCATOR_TOP_DEFINES_SVH
`define SEGREGATED_BEST_FIT_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define SBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define SBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sba_pkg.sv */
// Shared constants, types and helpers for the allocator.
`timescale 1ns / 1ps
package sba_pkg;
  localparam int FREE_SLOTS   = 64;
  localparam int USED_SLOTS   = 64;
  localparam int PAGE_COUNT   = 64;
  localparam int PAGE_BYTES   = 4096;
  localparam int BIN_COUNT    = 4;
  localparam int HEADER_BYTES = 16;
  localparam int BIN_SPAN     = 1000;
  localparam int PAGE_PAYLOAD = PAGE_BYTES - HEADER_BYTES;

  localparam int ADDR_W  = 18;
  localparam int SIZE_W  = 12;
  localparam int STAMP_W = 32;
  localparam int FIDX_W  = $clog2(FREE_SLOTS);
  localparam int UIDX_W  = $clog2(USED_SLOTS);
  localparam int PAGE_W  = $clog2(PAGE_COUNT + 1);
  localparam int BIN_W   = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int SCAN_LEN = (FREE_SLOTS > USED_SLOTS) ? FREE_SLOTS : USED_SLOTS;
  localparam int SCAN_W  = $clog2(SCAN_LEN + 1);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  // Size class of a byte count; size zero wraps into the top class.
  function automatic logic [BIN_W-1:0] bin_of(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] t;
    logic [BIN_W-1:0]  b;
    t = s - SIZE_W'(1);
    b = '0;
    for (int k = 1; k < BIN_COUNT; k++) begin
      if (t >= SIZE_W'(k * BIN_SPAN)) begin
        b = BIN_W'(k);
      end
    end
    return b;
  endfunction
endpackage

/* rtl/core/sba_if.sv */
// Handshake channel interfaces for request and response beats.
`timescale 1ns / 1ps
interface sba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [sba_pkg::SIZE_W-1:0]  size;
  logic [sba_pkg::ADDR_W-1:0]  address;
  modport source (output valid, operation, size, address, input ready);
  modport sink (input valid, operation, size, address, output ready);
endinterface

interface sba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [sba_pkg::ADDR_W-1:0]  address_res;
  logic [1:0]                  status;
  modport source (output valid, address_res, status, input ready);
  modport sink (input valid, address_res, status, output ready);
endinterface

/* rtl/core/sba_ctrl.sv */
// Sequencer that steps each request through load, table scan and finish.
`timescale 1ns / 1ps
module sba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sba_pkg::stat_t stat,
  output sba_pkg::cmd_t  cmd
);
  sba_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sba_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      sba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = sba_pkg::S_SCAN;
        end
      end
      sba_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = sba_pkg::S_FINISH;
        end
      end
      sba_pkg::S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = sba_pkg::S_IDLE;
        end
      end
      default: state_next = sba_pkg::S_IDLE;
    endcase
  end
endmodule

/* rtl/core/sba_dp.sv */
// Allocator datapath: block tables, scan compare, commit and result register.
`timescale 1ns / 1ps
module sba_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  sba_pkg::cmd_t              cmd,
  output sba_pkg::stat_t             stat,
  input  logic                       in_operation,
  input  logic [sba_pkg::SIZE_W-1:0] in_size,
  input  logic [sba_pkg::ADDR_W-1:0] in_address,
  sba_rsp_if.source                  rsp
);
  localparam int AW = sba_pkg::ADDR_W;
  localparam int SW = sba_pkg::SIZE_W;
  localparam int TW = sba_pkg::STAMP_W;
  localparam int FW = sba_pkg::FIDX_W;
  localparam int UW = sba_pkg::UIDX_W;
  localparam int CW = sba_pkg::SCAN_W;
  localparam int BW = sba_pkg::BIN_W;

  // Block tables.
  logic [AW-1:0] fa_mem [sba_pkg::FREE_SLOTS];
  logic [SW-1:0] fs_mem [sba_pkg::FREE_SLOTS];
  logic [TW-1:0] ft_mem [sba_pkg::FREE_SLOTS];
  logic [AW-1:0] ua_mem [sba_pkg::USED_SLOTS];
  logic [SW-1:0] us_mem [sba_pkg::USED_SLOTS];
  logic [sba_pkg::FREE_SLOTS-1:0] fvalid, fvalid_next;
  logic [sba_pkg::USED_SLOTS-1:0] uvalid, uvalid_next;

  logic [AW-1:0] fa_rd, ua_rd;
  logic [SW-1:0] fs_rd, us_rd;
  logic [TW-1:0] ft_rd;

  logic [sba_pkg::PAGE_W-1:0] pages;
  logic [TW-1:0]              counter;

  // Request held for the whole operation.
  logic          req_op;
  logic [SW-1:0] req_size;
  logic [AW-1:0] req_addr;

  // Scan pipeline.
  logic [CW-1:0] cnt, pidx;
  logic          pvld;

  logic          best_found;
  logic [FW-1:0] best_idx;
  logic [BW-1:0] best_bin;
  logic [SW-1:0] best_size;
  logic [TW-1:0] best_age;
  logic [AW-1:0] best_addr;
  logic          u_found;
  logic [UW-1:0] u_idx;
  logic [SW-1:0] u_size;

  // Open slots from the valid flags.
  logic          f_any, u_any;
  logic [FW-1:0] f_open;
  logic [UW-1:0] u_open;

  always_comb begin
    f_any = 1'b0;
    f_open = '0;
    for (int i = sba_pkg::FREE_SLOTS - 1; i >= 0; i--) begin
      if (!fvalid[i]) begin
        f_any = 1'b1;
        f_open = FW'(i);
      end
    end
  end

  always_comb begin
    u_any = 1'b0;
    u_open = '0;
    for (int i = sba_pkg::USED_SLOTS - 1; i >= 0; i--) begin
      if (!uvalid[i]) begin
        u_any = 1'b1;
        u_open = UW'(i);
      end
    end
  end

  // Compare of one scanned free entry against the best so far.
  logic [BW-1:0] c_bin, r_bin;
  logic [TW-1:0] c_age;
  logic          c_fit, c_better, u_hit;

  always_comb begin
    c_bin = sba_pkg::bin_of(fs_rd);
    r_bin = sba_pkg::bin_of(req_size);
    c_age = counter - ft_rd;
    c_fit = pvld && (pidx < CW'(sba_pkg::FREE_SLOTS)) && fvalid[FW'(pidx)]
            && (c_bin >= r_bin) && (fs_rd >= req_size);
    c_better = !best_found || (c_bin < best_bin) ||
               ((c_bin == best_bin) && ((fs_rd < best_size) ||
                ((fs_rd == best_size) && (c_age < best_age))));
    u_hit = pvld && (pidx < CW'(sba_pkg::USED_SLOTS)) && uvalid[UW'(pidx)]
            && (ua_rd == req_addr) && !u_found;
  end

  assign stat.scan_done = pvld && (pidx == CW'(sba_pkg::SCAN_LEN - 1));
  assign stat.out_free  = !rsp.valid || rsp.ready;

  // Commit decisions for the finish cycle.
  logic          f_we, f_clr, u_we, u_clr, page_inc, split;
  logic [FW-1:0] f_wi, f_ci;
  logic [AW-1:0] f_wa;
  logic [SW-1:0] f_ws;
  logic [TW-1:0] f_wt;
  logic [AW-1:0] res_addr;
  logic [1:0]    res_status;
  logic [AW-1:0] hdr, ptr;
  logic [SW-1:0] blk, rem;
  logic [FW-1:0] take;
  logic          have;

  always_comb begin
    f_we = 1'b0;
    f_clr = 1'b0;
    u_we = 1'b0;
    u_clr = 1'b0;
    page_inc = 1'b0;
    split = 1'b0;
    f_wi = '0;
    f_ci = '0;
    f_wa = '0;
    f_ws = '0;
    f_wt = counter;
    res_addr = '0;
    res_status = sba_pkg::ST_OK;
    have = 1'b0;
    take = best_idx;
    hdr = best_addr;
    blk = best_size;
    ptr = '0;
    rem = '0;
    if (req_op == sba_pkg::OP_ALLOC) begin
      if (!u_any) begin
        res_status = sba_pkg::ST_FULL;
      end else if (best_found) begin
        have = 1'b1;
      end else if ((req_size > SW'(sba_pkg::PAGE_PAYLOAD)) ||
                   (pages >= sba_pkg::PAGE_W'(sba_pkg::PAGE_COUNT)) || !f_any) begin
        res_status = sba_pkg::ST_FULL;
      end else begin
        // A fresh page is the only block that can fit after a failed search.
        have = 1'b1;
        page_inc = 1'b1;
        take = f_open;
        hdr = AW'(32'(pages) * sba_pkg::PAGE_BYTES);
        blk = SW'(sba_pkg::PAGE_PAYLOAD);
      end
      if (have) begin
        ptr = hdr + AW'(sba_pkg::HEADER_BYTES);
        rem = blk - req_size;
        split = rem > SW'(sba_pkg::HEADER_BYTES);
        f_clr = 1'b1;
        f_ci = take;
        f_we = split;
        f_wi = take;
        f_wa = ptr + AW'(req_size);
        f_ws = rem - SW'(sba_pkg::HEADER_BYTES);
        f_wt = counter + TW'(page_inc);
        u_we = 1'b1;
        res_addr = ptr;
      end
    end else begin
      if (!u_found) begin
        res_status = sba_pkg::ST_UNKNOWN;
      end else if (!f_any) begin
        res_status = sba_pkg::ST_FULL;
      end else begin
        u_clr = 1'b1;
        f_we = 1'b1;
        f_wi = f_open;
        f_wa = req_addr - AW'(sba_pkg::HEADER_BYTES);
        f_ws = u_size;
        f_wt = counter;
        split = 1'b1;
      end
    end
  end

  // A split writes back into the slot it just cleared, so the set wins.
  always_comb begin
    fvalid_next = fvalid;
    if (f_clr) begin
      fvalid_next[f_ci] = 1'b0;
    end
    if (f_we) begin
      fvalid_next[f_wi] = 1'b1;
    end
    uvalid_next = uvalid;
    if (u_we) begin
      uvalid_next[u_open] = 1'b1;
    end
    if (u_clr) begin
      uvalid_next[u_idx] = 1'b0;
    end
  end

  // Table storage.
  always_ff @(posedge clk) begin
    if (cmd.finish && f_we) begin
      fa_mem[f_wi] <= f_wa;
      fs_mem[f_wi] <= f_ws;
      ft_mem[f_wi] <= f_wt;
    end
    fa_rd <= fa_mem[FW'(cnt)];
    fs_rd <= fs_mem[FW'(cnt)];
    ft_rd <= ft_mem[FW'(cnt)];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && u_we) begin
      ua_mem[u_open] <= ptr;
      us_mem[u_open] <= req_size;
    end
    ua_rd <= ua_mem[UW'(cnt)];
    us_rd <= us_mem[UW'(cnt)];
  end

  // Valid flags, page count and insert counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= '0;
      uvalid <= '0;
      pages <= '0;
      counter <= '0;
    end else if (cmd.finish) begin
      fvalid <= fvalid_next;
      uvalid <= uvalid_next;
      pages <= pages + sba_pkg::PAGE_W'(page_inc);
      counter <= counter + TW'(page_inc) + TW'(split);
    end
  end

  // Scan control.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      pvld <= 1'b0;
      pidx <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
      pvld <= 1'b0;
    end else if (cmd.scan) begin
      pvld <= cnt != CW'(sba_pkg::SCAN_LEN);
      pidx <= cnt;
      if (cnt != CW'(sba_pkg::SCAN_LEN)) begin
        cnt <= cnt + CW'(1);
      end
    end else begin
      pvld <= 1'b0;
    end
  end

  // Request capture and best-candidate tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
      u_found <= 1'b0;
    end else if (cmd.load) begin
      best_found <= 1'b0;
      u_found <= 1'b0;
    end else begin
      if (c_fit && c_better) begin
        best_found <= 1'b1;
      end
      if (u_hit) begin
        u_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op <= in_operation;
      req_size <= in_size;
      req_addr <= in_address;
    end
    if (c_fit && c_better) begin
      best_idx <= FW'(pidx);
      best_bin <= c_bin;
      best_size <= fs_rd;
      best_age <= c_age;
      best_addr <= fa_rd;
    end
    if (u_hit) begin
      u_idx <= UW'(pidx);
      u_size <= us_rd;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.address_res <= res_addr;
      rsp.status <= res_status;
    end
  end
endmodule

/* rtl/core/segregated_best_fit_allocator_top.sv */
// Channel    Dir  Payload
// req        in   operation, size, address
// rsp        out  address_res, status
//
// Each request passes through a load step, a pipelined walk over both block
// tables, one entry per cycle on each table's read port, and a commit step.
// Reset (rst, synchronous) clears all valid flags, the page count and the insert
// counter; no clearing pass is needed. The commit waits while an earlier response
// beat is held; a new request is taken once the previous one has committed.
`timescale 1ns / 1ps
`include "segregated_best_fit_allocator_top_defines.svh"
module segregated_best_fit_allocator_top (
  input logic       clk,
  input logic       rst,
  sba_req_if.sink   req,
  sba_rsp_if.source rsp
);
  sba_pkg::cmd_t  cmd;
  sba_pkg::stat_t stat;
  logic           ready;

  assign req.ready = ready;

  sba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sba_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_operation (req.operation),
    .in_size      (req.size),
    .in_address   (req.address),
    .rsp          (rsp)
  );

  `SBA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "accepted while busy")
  `SBA_ASSERT_NEXT(a_finish_gives_beat, cmd.finish, rsp.valid, "commit without response")
  `SBA_ASSERT_NOW(a_error_zero_addr, rsp.valid && (rsp.status != sba_pkg::ST_OK), rsp.address_res == '0, "error with address")
endmodule
